### rtl/trvm_pkg.sv
// shared types and constants of the tagged register machine
`timescale 1ns / 1ps
package trvm_pkg;

  localparam logic [7:0] OP_NOP   = 8'h00;
  localparam logic [7:0] OP_RET   = 8'h01;
  localparam logic [7:0] OP_LDC   = 8'h04;
  localparam logic [7:0] OP_ADD   = 8'h10;
  localparam logic [7:0] OP_SUB   = 8'h11;
  localparam logic [7:0] OP_MUL   = 8'h12;
  localparam logic [7:0] OP_DIV   = 8'h13;
  localparam logic [7:0] OP_MOD   = 8'h14;
  localparam logic [7:0] OP_AND   = 8'h15;
  localparam logic [7:0] OP_OR    = 8'h16;
  localparam logic [7:0] OP_XOR   = 8'h17;
  localparam logic [7:0] OP_NAND  = 8'h18;
  localparam logic [7:0] OP_NOR   = 8'h19;
  localparam logic [7:0] OP_NXOR  = 8'h1A;
  localparam logic [7:0] OP_POP   = 8'h40;
  localparam logic [7:0] OP_PUSH  = 8'h41;

  localparam logic [1:0] TAG_NIL  = 2'd0;
  localparam logic [1:0] TAG_BOOL = 2'd1;
  localparam logic [1:0] TAG_INT  = 2'd2;
  localparam logic [1:0] TAG_FLT  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_TYPE    = 3'd2;
  localparam logic [2:0] ST_NOTINT  = 3'd3;
  localparam logic [2:0] ST_DIVZ    = 3'd4;
  localparam logic [2:0] ST_OVER    = 3'd5;
  localparam logic [2:0] ST_UNDER   = 3'd6;
  localparam logic [2:0] ST_UNKNOWN = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_DIV, S_POPRD, S_POPWR, S_OUT
  } state_t;

  // result selects for the register/output write
  typedef enum logic [2:0] {
    WR_NONE, WR_CONST, WR_ALU, WR_DIV, WR_STACK, WR_REG, WR_HALT
  } wsel_t;

  typedef struct packed {
    logic  load;      // capture input item
    logic  div_start;
    logic  stk_push;
    logic  sp_dec;
    logic  wr_reg;    // write selected value to reg_a
    wsel_t wsel;
    logic  out_load;
    logic  err_set;
    logic  [2:0] err_code;
  } ctrl_t;

  typedef struct packed {
    logic [7:0] op;
    logic       tag_ne;
    logic       tag_notint;
    logic       b_zero;
    logic       sp_full;
    logic       sp_empty;
    logic       div_done;
    logic [2:0] run_status;
  } stat_t;

endpackage

### rtl/trvm_if.sv
// valid/ready channel interfaces
`timescale 1ns / 1ps
interface trvm_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  op;
  logic [3:0]  reg_a;
  logic [3:0]  reg_b;
  logic [1:0]  const_type;
  logic [63:0] const_value;
  modport source (output valid, op, reg_a, reg_b, const_type, const_value, input ready);
  modport sink (input valid, op, reg_a, reg_b, const_type, const_value, output ready);
endinterface

interface trvm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  result_tag;
  logic [63:0] result_value;
  modport source (output valid, status, result_tag, result_value, input ready);
  modport sink (input valid, status, result_tag, result_value, output ready);
endinterface

### rtl/trvm_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module trvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### rtl/trvm_div.sv
// signed 32-bit divide/modulo, one quotient bit per cycle
`timescale 1ns / 1ps
module trvm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem
);
  logic [31:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, qn_r, qn_nxt, rn_r, rn_nxt;
  logic [32:0] trial;
  logic [31:0] sh;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; qn_nxt = qn_r; rn_nxt = rn_r;
    sh = {r_r[30:0], q_r[31]};
    trial = {1'b0, sh} - {1'b0, d_r};
    if (start) begin
      q_nxt = a[31] ? 32'd0 - a : a;
      d_nxt = b[31] ? 32'd0 - b : b;
      r_nxt = '0;
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
      qn_nxt = a[31] ^ b[31];
      rn_nxt = a[31];
    end else if (busy_r) begin
      if (!trial[32]) begin
        r_nxt = trial[31:0];
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        r_nxt = sh;
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt; qn_r <= qn_nxt; rn_r <= rn_nxt;
  end

  assign done = busy_r && (cnt_r == 6'd1);
  // sign fixup is applied to the final-step values
  assign quo  = qn_r ? 32'd0 - q_nxt : q_nxt;
  assign rem  = rn_r ? 32'd0 - r_nxt : r_nxt;
endmodule

### rtl/trvm_ctrl.sv
// instruction sequencer
`timescale 1ns / 1ps
module trvm_ctrl
  import trvm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t st,
  output ctrl_t ctl
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    ctl.wsel = WR_NONE;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.out_load = 1'b1;
        state_nxt = S_OUT;
        if (st.run_status == ST_HALT) begin
          ctl.wsel = WR_HALT;
        end else if (st.run_status != ST_OK) begin
          ctl.wsel = WR_NONE;
        end else if (st.op == OP_NOP) begin
          ctl.wsel = WR_NONE;
        end else if (st.op == OP_RET) begin
          ctl.wsel = WR_HALT;
          ctl.err_set = 1'b1;
          ctl.err_code = ST_HALT;
        end else if (st.op == OP_LDC) begin
          ctl.wsel = WR_CONST;
          ctl.wr_reg = 1'b1;
        end else if (st.op >= OP_ADD && st.op <= OP_NXOR) begin
          if (st.tag_ne) begin
            ctl.err_set = 1'b1; ctl.err_code = ST_TYPE;
          end else if (st.tag_notint) begin
            ctl.err_set = 1'b1; ctl.err_code = ST_NOTINT;
          end else if ((st.op == OP_DIV || st.op == OP_MOD) && st.b_zero) begin
            ctl.err_set = 1'b1; ctl.err_code = ST_DIVZ;
          end else if (st.op == OP_DIV || st.op == OP_MOD) begin
            ctl.out_load = 1'b0;
            ctl.div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            ctl.wsel = WR_ALU;
            ctl.wr_reg = 1'b1;
          end
        end else if (st.op == OP_PUSH) begin
          if (st.sp_full) begin
            ctl.err_set = 1'b1; ctl.err_code = ST_OVER;
          end else begin
            ctl.stk_push = 1'b1;
            ctl.wsel = WR_REG;
          end
        end else if (st.op == OP_POP) begin
          if (st.sp_empty) begin
            ctl.err_set = 1'b1; ctl.err_code = ST_UNDER;
          end else begin
            ctl.out_load = 1'b0;
            ctl.sp_dec = 1'b1;
            state_nxt = S_POPRD;
          end
        end else begin
          ctl.err_set = 1'b1; ctl.err_code = ST_UNKNOWN;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          ctl.wsel = WR_DIV;
          ctl.wr_reg = 1'b1;
          ctl.out_load = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_POPRD: begin
        // ram read issued at decremented pointer
        state_nxt = S_POPWR;
      end
      S_POPWR: begin
        ctl.wsel = WR_STACK;
        ctl.wr_reg = 1'b1;
        ctl.out_load = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        in_ready = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            ctl.load = 1'b1;
            state_nxt = S_EXEC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

### rtl/trvm_dp.sv
// register file, stack, alu and result register
`timescale 1ns / 1ps
module trvm_dp
  import trvm_pkg::*;
#(
  parameter int NUM_REGS = 16,
  parameter int STACK_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_t       ctl,
  output stat_t       st,
  input  logic [7:0]  op,
  input  logic [3:0]  reg_a,
  input  logic [3:0]  reg_b,
  input  logic [1:0]  const_type,
  input  logic [63:0] const_value,
  output logic [2:0]  status,
  output logic [1:0]  result_tag,
  output logic [63:0] result_value
);
  localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);

  logic [7:0]  op_r;
  logic [RW-1:0] ra_r, rb_r;
  logic [1:0]  ct_r;
  logic [63:0] cv_r;
  logic [1:0]  tags_r [NUM_REGS];
  logic [63:0] vals_r [NUM_REGS];
  logic [PW-1:0] sp_r;
  logic [2:0]  run_r;
  logic [2:0]  status_r;
  logic [1:0]  tag_r;
  logic [63:0] val_r;
  logic [31:0] a, b, alu;
  logic [31:0] mul_lo;
  logic [31:0] quo, rem;
  logic        div_done;
  logic [1:0]  stk_tag;
  logic [63:0] stk_val;
  logic [SW-1:0] stk_addr;
  logic [1:0]  w_tag;
  logic [63:0] w_val;
  logic [RW-1:0] ridx_lut [16];

  // register index wraps modulo the register count
  for (genvar g = 0; g < 16; g++) begin : g_ridx
    assign ridx_lut[g] = RW'(g % NUM_REGS);
  end

  assign a = vals_r[ra_r][31:0];
  assign b = vals_r[rb_r][31:0];
  assign mul_lo = a * b;

  always_comb begin
    case (op_r)
      OP_ADD:  alu = a + b;
      OP_SUB:  alu = a - b;
      OP_MUL:  alu = mul_lo;
      OP_AND:  alu = a & b;
      OP_OR:   alu = a | b;
      OP_XOR:  alu = a ^ b;
      OP_NAND: alu = ~(a & b);
      OP_NOR:  alu = ~(a | b);
      default: alu = ~(a ^ b);
    endcase
  end

  trvm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(ctl.div_start), .a(a), .b(b),
    .done(div_done), .quo(quo), .rem(rem)
  );

  // push writes at sp, pop reads at sp after decrement
  assign stk_addr = sp_r[SW-1:0] == '0 && sp_r == PW'(STACK_DEPTH) ? '0 : sp_r[SW-1:0];

  trvm_ram #(.WIDTH(2), .DEPTH(STACK_DEPTH)) u_stk_tag (
    .clk(clk), .we(ctl.stk_push), .addr(stk_addr), .wdata(tags_r[ra_r]), .rdata(stk_tag)
  );
  trvm_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stk_val (
    .clk(clk), .we(ctl.stk_push), .addr(stk_addr), .wdata(vals_r[ra_r]), .rdata(stk_val)
  );

  always_comb begin
    w_tag = TAG_NIL;
    w_val = '0;
    case (ctl.wsel)
      WR_CONST: begin
        w_tag = ct_r;
        case (ct_r)
          TAG_NIL:  w_val = '0;
          TAG_BOOL: w_val = {63'd0, |cv_r};
          TAG_INT:  w_val = {32'd0, cv_r[31:0]};
          default:  w_val = cv_r;
        endcase
      end
      WR_ALU:   begin w_tag = TAG_INT; w_val = {32'd0, alu}; end
      WR_DIV:   begin
        w_tag = TAG_INT;
        w_val = {32'd0, (op_r == OP_DIV) ? quo : rem};
      end
      WR_STACK: begin w_tag = stk_tag; w_val = stk_val; end
      WR_REG:   begin w_tag = tags_r[ra_r]; w_val = vals_r[ra_r]; end
      WR_HALT:  begin w_tag = tags_r[0]; w_val = vals_r[0]; end
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        tags_r[i] <= TAG_NIL;
        vals_r[i] <= '0;
      end
      sp_r  <= '0;
      run_r <= ST_OK;
    end else begin
      if (ctl.wr_reg) begin
        tags_r[ra_r] <= w_tag;
        vals_r[ra_r] <= w_val;
      end
      if (ctl.stk_push) sp_r <= sp_r + PW'(1);
      if (ctl.sp_dec)   sp_r <= sp_r - PW'(1);
      if (ctl.err_set)  run_r <= ctl.err_code;
    end
    if (ctl.load) begin
      op_r <= op;
      ra_r <= ridx_lut[reg_a];
      rb_r <= ridx_lut[reg_b];
      ct_r <= const_type;
      cv_r <= const_value;
    end
    if (ctl.out_load) begin
      status_r <= ctl.err_set ? ctl.err_code : run_r;
      tag_r    <= w_tag;
      val_r    <= w_val;
    end
  end

  assign st.op         = op_r;
  assign st.tag_ne     = tags_r[ra_r] != tags_r[rb_r];
  assign st.tag_notint = tags_r[ra_r] != TAG_INT;
  assign st.b_zero     = b == 32'd0;
  assign st.sp_full    = sp_r >= PW'(STACK_DEPTH);
  assign st.sp_empty   = sp_r == '0;
  assign st.div_done   = div_done;
  assign st.run_status = run_r;

  assign status       = status_r;
  assign result_tag   = tag_r;
  assign result_value = val_r;
endmodule

### rtl/tagged_register_vm_execute.sv
// top level of the tagged register machine execute block
`timescale 1ns / 1ps
// Executes one pre-decoded instruction per input item and returns one result item
// for it. Most instructions pass through the execute state and then the output
// register state; pop also passes through a read and a write-back state because
// of the registered read of the stack ram, and divide or modulo wait in a divide
// state for the one-bit-per-cycle divider. A new item is taken in the cycle
// its predecessor's result is taken. Errors and halt are sticky until reset;
// after one, every item returns the same status.
module tagged_register_vm_execute
  import trvm_pkg::*;
#(
  parameter int NUM_REGS = 16,
  parameter int STACK_DEPTH = 128
) (
  input logic clk,
  input logic rst_n,
  trvm_in_if.sink    in_ch,
  trvm_out_if.source out_ch
);
  ctrl_t ctl;
  stat_t st;

  trvm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .st(st), .ctl(ctl)
  );

  trvm_dp #(.NUM_REGS(NUM_REGS), .STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .st(st),
    .op(in_ch.op), .reg_a(in_ch.reg_a), .reg_b(in_ch.reg_b),
    .const_type(in_ch.const_type), .const_value(in_ch.const_value),
    .status(out_ch.status), .result_tag(out_ch.result_tag),
    .result_value(out_ch.result_value)
  );
endmodule

### rtl/trvm_checker.sv
// port-level checks of the execute block
`timescale 1ns / 1ps
module trvm_checker
  import trvm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status
);
  logic [2:0] last_st_r;
  logic       err_seen_r;

  // remember the latest non-ok status handed out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
      last_st_r  <= ST_OK;
    end else if (out_valid && out_ready && status != ST_OK) begin
      err_seen_r <= 1'b1;
      last_st_r  <= status;
    end
  end

  // result stays valid and its status stays stable while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result changed while stalled");
  // an item is accepted only when no result is pending or it is taken now
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("item accepted with pending result");
  // sticky error: every result after an error or halt repeats its status
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && err_seen_r |-> status == last_st_r)
    else $error("sticky status not repeated");
  // no result right after acceptance
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early");
endmodule

bind tagged_register_vm_execute trvm_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status)
);
